// ===== hw/rtl/tlb_page_walk_translator_assert.svh =====
// Assertion macros shared by the translator's checker.
`ifndef TLB_PAGE_WALK_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_WALK_TRANSLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TLBPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlbpw assertion failed");

// Next-cycle implication, disabled during reset.
`define TLBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlbpw assertion failed");

`endif

// ===== hw/rtl/tlbpw_pkg.sv =====
// Shared types and constants of the TLB page walk translator.
package tlbpw_pkg;

	localparam logic [15:0] LOW_BYTE_MASK = 16'h00FF;
	localparam logic [15:0] FRAME_MASK    = 16'hFF00;
	localparam logic [15:0] ACCESSED_BIT  = 16'h0020;
	localparam int          PRESENT_POS   = 0;
	localparam int          VPN_SHIFT     = 8;

	// word memory depth, a power of two so that index truncation wraps it
	localparam int          MEM_WORDS     = 65536;

	localparam logic FUNC_TRANSLATE = 1'b0;
	localparam logic FUNC_WRITE     = 1'b1;

	localparam logic [8:0] PAGE_SIZE_RESET = 9'd256;

	typedef struct packed {
		logic        en;
		logic [15:0] tag;
		logic [15:0] entry;
	} tlb_ins_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] entry;
	} tlb_res_t;

endpackage

// ===== hw/rtl/tlbpw_mem.sv =====
// Single-port word memory with registered read data.
module tlbpw_mem #(
	parameter int MEM_WORDS = 65536
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic                         we,
	input  logic [$clog2(MEM_WORDS)-1:0] addr,
	input  logic [15:0]                  wdata,
	output logic [15:0]                  rdata
);
	logic [15:0] mem_q [MEM_WORDS];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/tlbpw_tlb.sv =====
// Fully associative TLB with in-order fill and FIFO replacement.
module tlbpw_tlb #(
	parameter int TLB_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         lookup_tag,
	input  tlbpw_pkg::tlb_ins_t ins,
	output tlbpw_pkg::tlb_res_t res
);
	import tlbpw_pkg::*;

	localparam int SW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
	localparam int CW = $clog2(TLB_DEPTH + 1);

	logic [15:0]   tags_q    [TLB_DEPTH];
	logic [15:0]   entries_q [TLB_DEPTH];
	logic [CW-1:0] fill_q;
	logic [SW-1:0] oldest_q;
	logic          full;
	logic [SW-1:0] ins_slot;

	// tags are unique, so at most one slot matches
	always_comb begin
		res.hit   = 1'b0;
		res.entry = '0;
		for (int i = 0; i < TLB_DEPTH; i++) begin
			if ((CW'(i) < fill_q) && (tags_q[i] == lookup_tag)) begin
				res.hit   = 1'b1;
				res.entry = res.entry | entries_q[i];
			end
		end
	end

	assign full     = (fill_q == CW'(TLB_DEPTH));
	assign ins_slot = full ? oldest_q : fill_q[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
		end else if (ins.en) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end else if (oldest_q == SW'(TLB_DEPTH - 1)) begin
				oldest_q <= '0;
			end else begin
				oldest_q <= oldest_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins.en) begin
			tags_q[ins_slot]    <= ins.tag;
			entries_q[ins_slot] <= ins.entry;
		end
	end
endmodule

// ===== hw/rtl/tlb_page_walk_translator.sv =====
// Top level: sequencer driving the TLB and the shared word memory port.
// Usage:
//  Input channel in_valid/in_ready carries func, virt_addr, mem_address
//  and mem_data. func = 1 writes mem_data to the word memory, func = 0 translates.
//  Output channel out_valid/out_ready returns page_fault, tlb_hit,
//  physical_address and frame_data, one result per input transaction.
//  page_size is written through cfg_we/cfg_wdata; the user must do so only while the
//  block is idle, as the block itself does not enforce it. One transaction at a time;
//  in_ready is high only when the sequencer is idle. The single memory port
//  serializes the work: a miss needs a page entry read, the accessed-bit write
//  back and the frame read in turn. The result sits in an output register; while
//  the receiver stalls it holds, the next transaction may be accepted and worked on,
//  and its result waits until the register is taken.
//  Reset clears the TLB fill count and FIFO pointer, sets page_size to 256
//  and leaves the word memory contents undefined until written.
module tlb_page_walk_translator #(
	parameter int TLB_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] virt_addr,
	input  logic [15:0] mem_address,
	input  logic [15:0] mem_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        page_fault,
	output logic        tlb_hit,
	output logic [15:0] physical_address,
	output logic [15:0] frame_data
);
	import tlbpw_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_TAG   = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_PTE   = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DATA  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]  state_q;
	logic [8:0]  page_size_q;
	logic [15:0] va_q;
	logic [15:0] tag_q;
	logic [15:0] entry_q;
	logic        hit_q;
	logic        res_fault_q;
	logic        res_hit_q;
	logic [15:0] res_phys_q;
	logic [15:0] res_data_q;
	logic        out_valid_q;
	logic        out_fault_q;
	logic        out_hit_q;
	logic [15:0] out_phys_q;
	logic [15:0] out_data_q;

	logic        accept;
	logic        out_free;
	logic [15:0] product;
	logic [15:0] phys;
	logic        present;
	logic        mem_en;
	logic        mem_we;
	logic [15:0] mem_addr;
	logic [15:0] mem_wdata;
	logic [15:0] mem_rdata;
	tlb_ins_t    ins;
	tlb_res_t    res;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign product  = {8'd0, va_q[15:VPN_SHIFT]} * {7'd0, page_size_q};
	assign phys     = (entry_q & FRAME_MASK) + (va_q & LOW_BYTE_MASK);
	assign present  = entry_q[PRESENT_POS];

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = tag_q;
		mem_wdata = mem_rdata | ACCESSED_BIT;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (func == FUNC_WRITE)) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_addr  = mem_address;
					mem_wdata = mem_data;
				end
			end
			S_LOOK: begin
				mem_en = !res.hit;
			end
			S_PTE: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			S_CHECK: begin
				mem_en   = present;
				mem_addr = phys;
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		ins.en    = (state_q == S_CHECK) && present && !hit_q;
		ins.tag   = tag_q;
		ins.entry = entry_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			page_size_q <= PAGE_SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				page_size_q <= cfg_wdata;
			end
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (func == FUNC_WRITE) ? S_DONE : S_TAG;
					end
				end
				S_TAG: begin
					state_q <= S_LOOK;
				end
				S_LOOK: begin
					state_q <= res.hit ? S_CHECK : S_PTE;
				end
				S_PTE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= present ? S_DATA : S_DONE;
				end
				S_DATA: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				va_q        <= virt_addr;
				res_fault_q <= 1'b0;
				res_hit_q   <= 1'b0;
				res_phys_q  <= '0;
				res_data_q  <= '0;
			end
			S_TAG: begin
				tag_q <= product;
			end
			S_LOOK: begin
				hit_q   <= res.hit;
				entry_q <= res.entry;
			end
			S_PTE: begin
				entry_q <= mem_rdata | ACCESSED_BIT;
			end
			S_CHECK: begin
				res_fault_q <= !present;
				if (present) begin
					res_hit_q  <= hit_q;
					res_phys_q <= phys;
				end
			end
			S_DATA: begin
				res_data_q <= mem_rdata;
			end
			S_DONE: begin
				if (out_free) begin
					out_fault_q <= res_fault_q;
					out_hit_q   <= res_hit_q;
					out_phys_q  <= res_phys_q;
					out_data_q  <= res_data_q;
				end
			end
			default: begin
			end
		endcase
	end

	tlbpw_tlb #(
		.TLB_DEPTH(TLB_DEPTH)
	) u_tlb (
		.clk       (clk),
		.arst_n    (arst_n),
		.lookup_tag(tag_q),
		.ins       (ins),
		.res       (res)
	);

	tlbpw_mem #(
		.MEM_WORDS(MEM_WORDS)
	) u_mem (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr[AW-1:0]),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign out_valid        = out_valid_q;
	assign page_fault       = out_fault_q;
	assign tlb_hit          = out_hit_q;
	assign physical_address = out_phys_q;
	assign frame_data       = out_data_q;
endmodule

// ===== hw/rtl/tlbpw_checker.sv =====
// Port-level checker for the translator, bound to the top level.
`include "tlb_page_walk_translator_assert.svh"

module tlbpw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        page_fault,
	input logic        tlb_hit,
	input logic [15:0] physical_address,
	input logic [15:0] frame_data
);
	`TLBPW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TLBPW_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(physical_address) && $stable(frame_data) && $stable(page_fault))
	`TLBPW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`TLBPW_ASSERT_NOW(a_fault_zero, clk, arst_n, out_valid && page_fault, !tlb_hit && (physical_address == 16'd0) && (frame_data == 16'd0))
endmodule

bind tlb_page_walk_translator tlbpw_checker u_tlbpw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.page_fault      (page_fault),
	.tlb_hit         (tlb_hit),
	.physical_address(physical_address),
	.frame_data      (frame_data)
);

// ===== bench/tlb_page_walk_translator_tb.sv =====
// Self-checking testbench for the TLB page walk translator: directed table, then random traffic.
module tlb_page_walk_translator_tb;
	import tlbpw_pkg::*;

	localparam int TLB_DEPTH = 8;
	localparam int POOL = 12;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic        page_fault;
		logic        tlb_hit;
		logic [15:0] physical_address;
		logic [15:0] frame_data;
	} xlat_t;

	typedef struct packed {
		logic        f;
		logic [15:0] va;
		logic [15:0] ma;
		logic [15:0] md;
		logic        typed;
		xlat_t       want;
	} row_t;

	localparam xlat_t NIL = '0;
	localparam xlat_t FAULT = '{page_fault: 1'b1, default: '0};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [8:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [15:0] virt_addr;
	logic [15:0] mem_address;
	logic [15:0] mem_data;
	logic        out_valid;
	logic        out_ready;
	logic        page_fault;
	logic        tlb_hit;
	logic [15:0] physical_address;
	logic [15:0] frame_data;

	// shadow of the translator state
	logic [15:0] wmem [0:MEM_WORDS-1];
	bit          wmem_set [0:MEM_WORDS-1];
	logic [15:0] tlb_tag_q [0:TLB_DEPTH-1];
	logic [15:0] tlb_ent_q [0:TLB_DEPTH-1];
	int          tlb_fill;
	int          tlb_next;
	logic [8:0]  psize;

	xlat_t       xlat_due [$];
	int          n_bad;
	int          phase_items;
	int          hold_ask;
	bit          quiet;
	logic [7:0]  vpool [0:POOL-1];

	row_t directed_rows [0:16] = '{
		'{FUNC_WRITE,     16'h0000, 16'h0100, 16'h1201, 1'b1, NIL},
		'{FUNC_WRITE,     16'hFFFF, 16'h12FF, 16'hFFFF, 1'b1, NIL},
		'{FUNC_WRITE,     16'h0000, 16'h1200, 16'h0000, 1'b1, NIL},
		'{FUNC_TRANSLATE, 16'h01FF, 16'hFFFF, 16'hFFFF, 1'b0, NIL},
		'{FUNC_TRANSLATE, 16'h0100, 16'h0000, 16'h0000, 1'b0, NIL},
		'{FUNC_WRITE,     16'h1234, 16'h0200, 16'h3400, 1'b1, NIL},
		'{FUNC_TRANSLATE, 16'h02AB, 16'hFFFF, 16'h0000, 1'b1, FAULT},
		'{FUNC_TRANSLATE, 16'h0200, 16'h0000, 16'hFFFF, 1'b1, FAULT},
		'{FUNC_WRITE,     16'h0000, 16'hFF00, 16'hFF01, 1'b1, NIL},
		'{FUNC_WRITE,     16'hFFFF, 16'hFFFF, 16'hA5A5, 1'b1, NIL},
		'{FUNC_TRANSLATE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, NIL},
		'{FUNC_TRANSLATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NIL},
		'{FUNC_WRITE,     16'h0000, 16'h0000, 16'h0001, 1'b1, NIL},
		// frame word is the page entry itself, accessed bit already set
		'{FUNC_TRANSLATE, 16'h0000, 16'h0000, 16'h0000, 1'b0, NIL},
		'{FUNC_WRITE,     16'h0000, 16'h0100, 16'h0000, 1'b1, NIL},
		// cached entry still present after the table entry is cleared
		'{FUNC_TRANSLATE, 16'h01FF, 16'h0000, 16'h0000, 1'b0, NIL},
		'{FUNC_TRANSLATE, 16'h02FF, 16'h0000, 16'h0000, 1'b1, FAULT}
	};

	tlb_page_walk_translator #(
		.TLB_DEPTH(TLB_DEPTH)
	) u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] page_tag(logic [7:0] vpn);
		return 16'(32'(vpn) * 32'(psize));
	endfunction

	function automatic logic [15:0] fresh_pte();
		return {8'($urandom), 7'($urandom), 1'($urandom_range(0, 99) < 85)};
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int sender_gap();
		if (quiet || $urandom_range(0, 99) < 60)
			return 0;
		return idle_len();
	endfunction

	function automatic int tlb_slot(logic [15:0] tag);
		for (int i = 0; i < tlb_fill; i++)
			if (tlb_tag_q[i] == tag)
				return i;
		return -1;
	endfunction

	// one transaction through the shadow state
	function automatic xlat_t walk_page(logic f, logic [15:0] va, logic [15:0] ma,
			logic [15:0] md);
		xlat_t       r;
		logic [15:0] tag;
		logic [15:0] ent;
		logic [15:0] pa;
		int          slot;
		r = '0;
		if (f == FUNC_WRITE) begin
			wmem[ma] = md;
			wmem_set[ma] = 1'b1;
			return r;
		end
		tag = page_tag(va[15:8]);
		slot = tlb_slot(tag);
		if (slot >= 0) begin
			ent = tlb_ent_q[slot];
		end else begin
			ent = wmem[tag] | ACCESSED_BIT;
			wmem[tag] = ent;
			wmem_set[tag] = 1'b1;
		end
		if (!ent[PRESENT_POS]) begin
			r.page_fault = 1'b1;
			return r;
		end
		pa = (ent & FRAME_MASK) + {8'h00, va[7:0]};
		r.tlb_hit = slot >= 0;
		r.physical_address = pa;
		r.frame_data = wmem[pa];
		if (slot < 0) begin
			if (tlb_fill < TLB_DEPTH) begin
				tlb_tag_q[tlb_fill] = tag;
				tlb_ent_q[tlb_fill] = ent;
				tlb_fill++;
			end else begin
				tlb_tag_q[tlb_next] = tag;
				tlb_ent_q[tlb_next] = ent;
				tlb_next = (tlb_next + 1) % TLB_DEPTH;
			end
		end
		return r;
	endfunction

	task automatic put_item(logic f, logic [15:0] va, logic [15:0] ma, logic [15:0] md,
			logic typed, xlat_t want);
		int    gap;
		xlat_t pred;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		virt_addr <= va;
		mem_address <= ma;
		mem_data <= md;
		do @(posedge clk); while (!in_ready);
		pred = walk_page(f, va, ma, md);
		xlat_due.push_back(typed ? want : pred);
		phase_items++;
	endtask

	// writes whatever the walk would read before it has ever been written
	task automatic translate_safely(logic [15:0] va);
		logic [15:0] tag;
		logic [15:0] ent;
		logic [15:0] pa;
		int          slot;
		tag = page_tag(va[15:8]);
		slot = tlb_slot(tag);
		if (slot < 0 && !wmem_set[tag])
			put_item(FUNC_WRITE, rand16(), tag, fresh_pte(), 1'b0, NIL);
		ent = (slot >= 0) ? tlb_ent_q[slot] : (wmem[tag] | ACCESSED_BIT);
		if (ent[PRESENT_POS]) begin
			pa = (ent & FRAME_MASK) + {8'h00, va[7:0]};
			if (!wmem_set[pa])
				put_item(FUNC_WRITE, rand16(), pa, rand16(), 1'b0, NIL);
		end
		put_item(FUNC_TRANSLATE, va, rand16(), rand16(), 1'b0, NIL);
	endtask

	task automatic random_step();
		int          r;
		logic [15:0] va;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			put_item(FUNC_WRITE, rand16(), rand16(), rand16(), 1'b0, NIL);
		end else if (r < 17) begin
			put_item(FUNC_WRITE, rand16(), page_tag(vpool[$urandom_range(0, POOL-1)]),
				fresh_pte(), 1'b0, NIL);
		end else begin
			va[15:8] = ($urandom_range(0, 4) != 0) ? vpool[$urandom_range(0, POOL-1)]
				: 8'($urandom);
			case ($urandom_range(0, 5))
				0: va[7:0] = 8'h00;
				1: va[7:0] = 8'hFF;
				default: va[7:0] = 8'($urandom);
			endcase
			translate_safely(va);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (xlat_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_page_size(logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		psize = v;
	endtask

	task automatic cmp_field(string name, logic [15:0] e, logic [15:0] a);
		if (a !== e) begin
			$error("%s: expected %h, got %h", name, e, a);
			n_bad++;
		end
	endtask

	initial begin : result_side
		int    stall;
		int    hold_done;
		xlat_t want;
		stall = 0;
		hold_done = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (xlat_due.size() == 0) begin
					$error("result transaction with nothing outstanding");
					n_bad++;
				end else begin
					want = xlat_due.pop_front();
					cmp_field("page_fault", 16'(want.page_fault), 16'(page_fault));
					cmp_field("tlb_hit", 16'(want.tlb_hit), 16'(tlb_hit));
					cmp_field("physical_address", want.physical_address, physical_address);
					cmp_field("frame_data", want.frame_data, frame_data);
				end
			end
			if (hold_ask != hold_done) begin
				hold_done = hold_ask;
				stall = 400;
			end else if (stall == 0 && !quiet && $urandom_range(0, 99) < 25) begin
				stall = idle_len();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic [8:0] sizes [0:7];
		n_bad = 0;
		phase_items = 0;
		hold_ask = 0;
		quiet = 1'b0;
		tlb_fill = 0;
		tlb_next = 0;
		psize = PAGE_SIZE_RESET;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		func <= FUNC_TRANSLATE;
		virt_addr <= '0;
		mem_address <= '0;
		mem_data <= '0;
		sizes = '{9'd1, 9'd0, 9'd511, 9'd256, 9'd257, 9'd2,
			9'($urandom_range(3, 255)), 9'($urandom_range(258, 510))};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			put_item(directed_rows[i].f, directed_rows[i].va, directed_rows[i].ma,
				directed_rows[i].md, directed_rows[i].typed, directed_rows[i].want);

		for (int p = 0; p < 8; p++) begin
			settle();
			set_page_size(sizes[p]);
			foreach (vpool[i])
				vpool[i] = 8'($urandom);
			quiet = (p == 3);
			// long output stall while input keeps coming
			if (p == 1)
				hold_ask++;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				random_step();
		end

		settle();
		repeat (20) @(posedge clk);
		if (n_bad == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
